[hw/rtl/oqc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqc_pkg
// Shared types and constants for the ordered queue with cursor.
// ----------------------------------------------------------------------------
package oqc_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int KIND_W         = 3;
    localparam int STATUS_W       = 2;

    typedef enum logic [KIND_W-1:0] {
        K_ENQUEUE    = 3'd0,
        K_DEQUEUE    = 3'd1,
        K_CUR_RESET  = 3'd2,
        K_CUR_FRONT  = 3'd3,
        K_CUR_BACK   = 3'd4,
        K_READ       = 3'd5,
        K_INSERT     = 3'd6,
        K_DELETE     = 3'd7
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_NULL  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic take_din;
        logic take_left;
        logic take_right;
    } t_cell_op;

endpackage

[hw/rtl/ordered_queue_with_cursor_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_queue_with_cursor_top
// Bounded ordered queue with one cursor, kept in a shifting chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_t*): one operation per word. s_tuser carries the kind
//   (enqueue, dequeue, cursor reset/step, read, insert, delete), s_tdata the
//   word for enqueue or insert.
//   Master channel (m_t*): exactly one result word per operation, holding the
//   word read, a status code, the cursor neighbor flags and the occupancy.
//   Output: the result is registered and presented in the cycle after the operation is taken.
//   Throughput: one operation per cycle unless a result is stalled; all
//   cells of the chain shift or load in parallel, so insert and delete at
//   any place happen at once. Cursor read: a one-hot select across all cells.
//   Stall: a result waiting in the output register is held while m_tready is
//   low; s_tready drops until it is taken, and is high again in the cycle it
//   is taken.
//   Reset (i_rst_n low, synchronous): queue empty, cursor null, no result
//   pending. Cell contents are not cleared; only filled cells are ever read.
// ----------------------------------------------------------------------------
module ordered_queue_with_cursor_top
    import oqc_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int IN_W      = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_RAW_W = DATA_WIDTH + STATUS_W + 2 + CNT_W,
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,  // data_in
    input  logic [KIND_W-1:0] s_tuser,  // kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata   // data_out, status, has_toward_front,
                                        // has_toward_back, occupancy
);

    logic [DATA_WIDTH-1:0] w_cell [DEPTH];
    t_cell_op              w_op   [DEPTH];

    logic                  r_mvalid;
    logic [OUT_W-1:0]      r_mdata;
    logic [CNT_W-1:0]      r_count;
    logic [PTR_W-1:0]      r_pos;
    logic                  r_valid;

    logic [CNT_W-1:0]      n_count;
    logic [PTR_W-1:0]      n_pos;
    logic                  n_valid;

    logic                  accept;
    t_kind                 kind;
    logic [DATA_WIDTH-1:0] din;
    logic                  full;
    logic [CNT_W-1:0]      pos_ext;
    logic [CNT_W-1:0]      cnt_dec;
    logic                  ins;
    logic                  rem;
    logic [PTR_W-1:0]      idx;
    t_status               status;
    logic [DATA_WIDTH-1:0] dout;
    logic [DATA_WIDTH-1:0] cur_word;
    logic                  has_front;
    logic                  has_back;
    logic [OUT_RAW_W-1:0]  result;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !r_mvalid || m_tready;
    assign kind     = t_kind'(s_tuser);
    assign din      = s_tdata[DATA_WIDTH-1:0];
    assign full     = (r_count == CNT_W'(DEPTH));
    assign pos_ext  = CNT_W'(r_pos);
    assign cnt_dec  = r_count - CNT_W'(1);

    // word under the cursor
    always_comb begin
        cur_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            cur_word = cur_word | (w_cell[i] & {DATA_WIDTH{r_pos == PTR_W'(i)}});
        end
    end

    always_comb begin
        n_count = r_count;
        n_pos   = r_pos;
        n_valid = r_valid;
        ins     = 1'b0;
        rem     = 1'b0;
        idx     = '0;
        status  = ST_OK;
        dout    = '0;
        case (kind)
            K_ENQUEUE: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ins     = 1'b1;
                    idx     = r_count[PTR_W-1:0];
                    n_count = r_count + CNT_W'(1);
                end
            end
            K_DEQUEUE: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    dout    = w_cell[0];
                    rem     = 1'b1;
                    n_count = cnt_dec;
                    if (r_valid) begin
                        if (r_pos == '0) begin
                            n_valid = 1'b0;
                        end else begin
                            n_pos = r_pos - PTR_W'(1);
                        end
                    end
                end
            end
            K_CUR_RESET: begin
                if (r_count == '0) begin
                    n_valid = 1'b0;
                    n_pos   = '0;
                end else begin
                    n_valid = 1'b1;
                    n_pos   = cnt_dec[PTR_W-1:0];
                end
            end
            K_CUR_FRONT: begin
                if (!r_valid) begin
                    status = ST_NULL;
                end else if (r_pos == '0) begin
                    n_valid = 1'b0;
                end else begin
                    n_pos = r_pos - PTR_W'(1);
                end
            end
            K_CUR_BACK: begin
                if (!r_valid) begin
                    status = ST_NULL;
                end else if ((pos_ext + CNT_W'(1)) >= r_count) begin
                    n_valid = 1'b0;
                end else begin
                    n_pos = r_pos + PTR_W'(1);
                end
            end
            K_READ: begin
                if (!r_valid) begin
                    status = ST_NULL;
                end else begin
                    dout = cur_word;
                end
            end
            K_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ins     = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (!r_valid || r_count == '0) begin
                        idx = r_count[PTR_W-1:0];
                    end else begin
                        idx = r_pos + PTR_W'(1);
                    end
                end
            end
            K_DELETE: begin
                if (!r_valid) begin
                    status = ST_NULL;
                end else begin
                    rem     = 1'b1;
                    idx     = r_pos;
                    n_count = cnt_dec;
                    if (cnt_dec == '0) begin
                        n_valid = 1'b0;
                        n_pos   = '0;
                    end else if (pos_ext >= cnt_dec) begin
                        n_pos = PTR_W'(cnt_dec - CNT_W'(1));
                    end
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign has_front = n_valid && (n_pos != '0);
    assign has_back  = n_valid && ((CNT_W'(n_pos) + CNT_W'(1)) < n_count);
    assign result    = {n_count, has_back, has_front, status, dout};

    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            localparam logic [PTR_W-1:0] CIDX = PTR_W'(g);
            localparam int LEFT  = (g == 0) ? 0 : g - 1;
            localparam int RIGHT = (g == DEPTH - 1) ? DEPTH - 1 : g + 1;

            assign w_op[g].take_din   = accept && ins && (CIDX == idx);
            assign w_op[g].take_left  = accept && ins && (CIDX > idx);
            assign w_op[g].take_right = accept && rem && (CIDX >= idx);

            oqc_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op[g]),
                .i_din   (din),
                .i_left  (w_cell[LEFT]),
                .i_right (w_cell[RIGHT]),
                .o_data  (w_cell[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pos    <= '0;
            r_valid  <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            if (accept) begin
                r_count  <= n_count;
                r_pos    <= n_pos;
                r_valid  <= n_valid;
                r_mvalid <= 1'b1;
            end else if (m_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mdata <= OUT_W'(result);
        end
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;

endmodule

[hw/rtl/oqc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqc_cell
// One storage cell of the shifting chain: holds, loads a new word, or takes
// the word of its neighbor on either side.
// ----------------------------------------------------------------------------
module oqc_cell
    import oqc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [DATA_WIDTH-1:0] i_din,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        if (i_op.take_din) begin
            n_data = i_din;
        end else if (i_op.take_left) begin
            n_data = i_left;
        end else if (i_op.take_right) begin
            n_data = i_right;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[hw/rtl/oqc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqc_port_checks
// Port-level checks on the result stream of the ordered queue with cursor.
// ----------------------------------------------------------------------------
module oqc_port_checks
    import oqc_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int OUT_RAW_W = DATA_WIDTH + STATUS_W + 2 + CNT_W,
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] i_m_tdata
);

    logic [DATA_WIDTH-1:0] data_out;
    t_status               status;
    logic                  has_front;
    logic                  has_back;
    logic [CNT_W-1:0]      occupancy;

    assign data_out  = i_m_tdata[DATA_WIDTH-1:0];
    assign status    = t_status'(i_m_tdata[DATA_WIDTH +: STATUS_W]);
    assign has_front = i_m_tdata[DATA_WIDTH + STATUS_W];
    assign has_back  = i_m_tdata[DATA_WIDTH + STATUS_W + 1];
    assign occupancy = i_m_tdata[DATA_WIDTH + STATUS_W + 2 +: CNT_W];

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result changed while stalled");

    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> occupancy <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    // a null cursor stays null, so no neighbor can be reported
    a_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && status == ST_NULL |-> !has_front && !has_back && data_out == '0)
        else $error("null cursor with neighbor flags or data");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && status == ST_FULL |-> occupancy == CNT_W'(DEPTH) && data_out == '0)
        else $error("full status below depth");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && status == ST_EMPTY |-> occupancy == '0 && !has_front && !has_back)
        else $error("empty status with entries");

endmodule

bind ordered_queue_with_cursor_top oqc_port_checks #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_oqc_port_checks (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_tvalid),
    .i_m_tready (m_tready),
    .i_m_tdata  (m_tdata)
);
